[rtl/assert_macros.svh]
// Assertion helpers shared by the vertex normal accumulator RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock, off while in reset.
`define VNA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("vna assertion failed");

// Consequent checked at the clock after the antecedent.
`define VNA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vna assertion failed");

`endif

[rtl/vna_pkg.sv]
// Shared types and constants for the vertex normal accumulator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package vna_pkg;

	localparam int VNA_MAX_VERTICES = 1024;
	localparam int VNA_ACCUM_BITS   = 48;
	// step counter covers the longest loop (square root, up to 64 digits)
	localparam int STEP_W           = 6;

	typedef enum logic [1:0] {
		ACT_VADD = 2'd0,
		ACT_TRI  = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_IDX  = 2'd2,
		STAT_RSVD = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_TPOS, ST_TCROSS, ST_TACC,
		ST_RLOAD, ST_RSQ, ST_RSQRT, ST_RDIV, ST_DONE
	} vna_state_t;

	typedef enum logic [3:0] {
		DP_NOP, DP_LOAD, DP_VADD, DP_ERR_FULL, DP_ERR_IDX, DP_PRD, DP_XMUL,
		DP_ACC, DP_RLD, DP_SQ, DP_SQRT, DP_DIV, DP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [1:0]          sel;
		logic [STEP_W-1:0]   step;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       full;
		logic       tri_bad;
		logic       rd_bad;
	} dp_stat_t;

endpackage

[rtl/vertex_normal_accumulator.sv]
// Top level of the vertex normal accumulator: sequencer plus datapath.
// Depends on vna_pkg, vna_ctrl and vna_dp.
`timescale 1ns / 1ps

// Area-weighted vertex normals, built up as triangles arrive. One beat in
// gives one result beat out. An add-triangle beat makes three position
// reads, a cross product on one shared 17x17 multiplier and three
// read-modify-writes of the accumulator memory; a read beat runs the
// 13-step chunked squaring, the one-digit-per-cycle square root and a
// shared 16-step divider run once per component. A finished result sits
// in an output register, so the next beat is taken while it waits. No
// clearing pass is needed after reset.
module vertex_normal_accumulator #(
	parameter int MAX_VERTICES = vna_pkg::VNA_MAX_VERTICES,
	parameter int ACCUM_BITS   = vna_pkg::VNA_ACCUM_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [9:0]         vertex_index,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z
);
	import vna_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	vna_ctrl #(
		.ACCUM_BITS(ACCUM_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vna_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.ACCUM_BITS  (ACCUM_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.status       (status),
		.vertex_index (vertex_index),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z)
	);

endmodule

[rtl/vna_ctrl.sv]
// Sequencer for the vertex normal accumulator: walks each beat through
// its datapath steps and owns the result handshake. Uses vna_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vna_ctrl #(
	parameter int ACCUM_BITS = vna_pkg::VNA_ACCUM_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  vna_pkg::dp_stat_t stat,
	output vna_pkg::dp_cmd_t  cmd
);
	import vna_pkg::*;

	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ACCUM_BITS - 1);

	vna_state_t        state_q, state_n;
	logic [STEP_W-1:0] cnt_q, cnt_n;
	logic [1:0]        sel_q, sel_n;
	logic              out_valid_q, out_valid_n;

	// state, counters, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			cnt_q       <= cnt_n;
			sel_q       <= sel_n;
			out_valid_q <= out_valid_n;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_n  = state_q;
		cnt_n    = cnt_q + 1'b1;
		sel_n    = sel_q;
		in_ready = 1'b0;
		cmd.op   = DP_NOP;
		cmd.sel  = 2'd0;
		cmd.step = cnt_q;
		out_valid_n = (out_valid_q && !out_ready);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cnt_n    = '0;
				sel_n    = '0;
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_n = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cnt_n = '0;
				case (act_t'(stat.act))
					ACT_VADD: begin
						cmd.op  = stat.full ? DP_ERR_FULL : DP_VADD;
						state_n = ST_DONE;
					end
					ACT_TRI: begin
						if (stat.tri_bad) begin
							cmd.op  = DP_ERR_IDX;
							state_n = ST_DONE;
						end else begin
							state_n = ST_TPOS;
						end
					end
					ACT_READ: begin
						if (stat.rd_bad) begin
							cmd.op  = DP_ERR_IDX;
							state_n = ST_DONE;
						end else begin
							state_n = ST_RLOAD;
						end
					end
					default: state_n = ST_DONE;
				endcase
			end
			ST_TPOS: begin
				cmd.op  = DP_PRD;
				cmd.sel = cnt_q[1:0];
				if (cnt_q == STEP_W'(3)) begin
					cnt_n   = '0;
					state_n = ST_TCROSS;
				end
			end
			ST_TCROSS: begin
				cmd.op = DP_XMUL;
				if (cnt_q == STEP_W'(7)) begin
					cnt_n   = '0;
					state_n = ST_TACC;
				end
			end
			ST_TACC: begin
				cmd.op  = DP_ACC;
				cmd.sel = cnt_q[2:1];
				if (cnt_q == STEP_W'(5)) begin
					state_n = ST_DONE;
				end
			end
			ST_RLOAD: begin
				cmd.op = DP_RLD;
				if (cnt_q == STEP_W'(1)) begin
					cnt_n   = '0;
					state_n = ST_RSQ;
				end
			end
			ST_RSQ: begin
				cmd.op = DP_SQ;
				if (cnt_q == STEP_W'(12)) begin
					cnt_n   = '0;
					state_n = ST_RSQRT;
				end
			end
			ST_RSQRT: begin
				cmd.op = DP_SQRT;
				if (cnt_q == SQRT_LAST) begin
					cnt_n   = '0;
					sel_n   = '0;
					state_n = ST_RDIV;
				end
			end
			ST_RDIV: begin
				cmd.op  = DP_DIV;
				cmd.sel = sel_q;
				if (cnt_q == STEP_W'(15)) begin
					cnt_n = '0;
					sel_n = sel_q + 1'b1;
					if (sel_q == 2'd2) begin
						state_n = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = DP_FIN;
					out_valid_n = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	// a pending result is never overwritten
	`VNA_ASSERT(a_fin_free, (cmd.op == DP_FIN) |-> (!out_valid_q || out_ready))
	// an accepted beat is decoded next
	`VNA_ASSERT_NEXT(a_accept_dec, in_valid && in_ready, state_q == ST_DECODE)
	// divider walks three components only
	`VNA_ASSERT(a_div_sel, (state_q == ST_RDIV) |-> (sel_q != 2'd3))

endmodule

[rtl/vna_dp.sv]
// Datapath of the vertex normal accumulator: position and accumulator
// memories, cross product, square root and divider. Uses vna_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vna_dp #(
	parameter int MAX_VERTICES = vna_pkg::VNA_MAX_VERTICES,
	parameter int ACCUM_BITS   = vna_pkg::VNA_ACCUM_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vna_pkg::dp_cmd_t   cmd,
	output vna_pkg::dp_stat_t  stat,
	input  logic [1:0]         action,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	output logic [1:0]         status,
	output logic [9:0]         vertex_index,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z
);
	import vna_pkg::*;

	localparam int AB    = ACCUM_BITS;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int EXT_W = (IDX_W > 10) ? IDX_W : 10;
	localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;
	localparam int SUM_W = 2 * AB;
	localparam int REM_W = AB + 2;

	// input beat
	logic [1:0]         act_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic [9:0]         ca_q, cb_q, cc_q;
	logic [CNT_W-1:0]   count_q;

	// memories
	logic [47:0]       pos_mem [MAX_VERTICES];
	logic [3*AB-1:0]   acc_mem [MAX_VERTICES];
	logic [47:0]       pos_rd_q;
	logic [3*AB-1:0]   acc_rd_q;

	// triangle work registers
	logic signed [15:0] vp_q [3][3];
	logic signed [16:0] e1_q [3];
	logic signed [16:0] e2_q [3];
	logic signed [33:0] prod_s1;
	logic signed [35:0] cross_q [3];

	// normal work registers
	logic [AB-1:0]     mag_q [3];
	logic              sgn_q [3];
	logic [63:0]       sq_prod_s1;
	logic [1:0]        sq_sh_s1;
	logic [SUM_W-1:0]  sum_q;
	logic [REM_W-1:0]  rem_q;
	logic [AB-1:0]     root_q;
	logic [AB:0]       dr_q;
	logic [14:0]       q_q;

	// result
	logic [1:0]         res_status_q;
	logic [9:0]         res_vidx_q;
	logic signed [15:0] nrm_q [3];

	// address selection
	logic [9:0]        crn;
	logic [EXT_W-1:0]  crn_ext;
	logic [IDX_W-1:0]  rd_addr, cnt_addr;
	logic [CMP_W-1:0]  cnt_cmp;
	logic [1:0]        cap_idx;

	always_comb begin
		case (cmd.sel)
			2'd0:    crn = ca_q;
			2'd1:    crn = cb_q;
			default: crn = cc_q;
		endcase
	end
	assign crn_ext  = EXT_W'(crn);
	assign rd_addr  = crn_ext[IDX_W-1:0];
	assign cnt_addr = count_q[IDX_W-1:0];
	assign cnt_cmp  = CMP_W'(count_q);
	assign cap_idx  = 2'(cmd.step - 1'b1);

	// status toward the controller
	assign stat.act     = act_q;
	assign stat.full    = (count_q == CNT_W'(MAX_VERTICES));
	assign stat.rd_bad  = (CMP_W'(ca_q) >= cnt_cmp);
	assign stat.tri_bad = stat.rd_bad || (CMP_W'(cb_q) >= cnt_cmp)
		|| (CMP_W'(cc_q) >= cnt_cmp);

	// saturating accumulator add
	function automatic logic [AB-1:0] sat_add(input logic [AB-1:0] a,
		input logic signed [35:0] d);
		logic signed [AB:0] s;
		s = $signed({a[AB-1], a}) + $signed({{(AB - 35){d[35]}}, d});
		if (s[AB] != s[AB-1])
			return s[AB] ? {1'b1, {(AB - 1){1'b0}}} : {1'b0, {(AB - 1){1'b1}}};
		return s[AB-1:0];
	endfunction

	logic [3*AB-1:0] acc_new;
	always_comb begin
		for (int k = 0; k < 3; k++)
			acc_new[k*AB +: AB] = sat_add(acc_rd_q[k*AB +: AB], cross_q[k]);
	end

	logic acc_we;
	assign acc_we = (cmd.op == DP_VADD) || ((cmd.op == DP_ACC) && cmd.step[0]);

	// position memory
	always_ff @(posedge clk) begin
		if (cmd.op == DP_VADD)
			pos_mem[cnt_addr] <= {pz_q, py_q, px_q};
		pos_rd_q <= pos_mem[rd_addr];
	end

	// accumulator memory, cleared entry on vertex add
	always_ff @(posedge clk) begin
		if (acc_we) begin
			if (cmd.op == DP_VADD)
				acc_mem[cnt_addr] <= '0;
			else
				acc_mem[rd_addr] <= acc_new;
		end
		acc_rd_q <= acc_mem[rd_addr];
	end

	// vertex count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == DP_VADD) begin
			count_q <= count_q + 1'b1;
		end
	end

	// cross product multiplier operands
	logic signed [16:0] mul_a, mul_b;
	always_comb begin
		case (cmd.step)
			STEP_W'(1): begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			STEP_W'(2): begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			STEP_W'(3): begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			STEP_W'(4): begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			STEP_W'(5): begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			default:    begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
		endcase
	end

	// square operand chunks
	logic [63:0] m64;
	logic [31:0] sq_a, sq_b;
	always_comb begin
		case (cmd.step[3:2])
			2'd0:    m64 = 64'(mag_q[0]);
			2'd1:    m64 = 64'(mag_q[1]);
			2'd2:    m64 = 64'(mag_q[2]);
			default: m64 = '0;
		endcase
		sq_a = cmd.step[1] ? m64[63:32] : m64[31:0];
		sq_b = cmd.step[0] ? m64[63:32] : m64[31:0];
	end

	logic [127:0] sq_ext;
	assign sq_ext = 128'(sq_prod_s1) << {sq_sh_s1, 5'd0};

	// square root digit
	logic [REM_W-1:0] rem_n, trial;
	assign rem_n = {rem_q[REM_W-3:0], sum_q[SUM_W-1 -: 2]};
	assign trial = {root_q, 2'b01};

	// divider step
	logic [AB:0]      len_ext, dr_sh, m_ext;
	logic [1:0]       dsel;
	logic [15:0]      qext;
	assign len_ext = (AB + 1)'(root_q);
	assign dr_sh   = {dr_q[AB-1:0], 1'b0};
	assign dsel    = (cmd.sel == 2'd3) ? 2'd2 : cmd.sel;
	assign m_ext   = (AB + 1)'(mag_q[dsel]);
	assign qext    = {1'b0, q_q};

	// work registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				act_q <= action;
				px_q  <= pos_x;
				py_q  <= pos_y;
				pz_q  <= pos_z;
				ca_q  <= corner_a;
				cb_q  <= corner_b;
				cc_q  <= corner_c;
				res_status_q <= STAT_OK;
				res_vidx_q   <= '0;
				for (int k = 0; k < 3; k++) nrm_q[k] <= '0;
			end
			DP_VADD: res_vidx_q <= cnt_cmp[9:0];
			DP_ERR_FULL: res_status_q <= STAT_FULL;
			DP_ERR_IDX: res_status_q <= STAT_IDX;
			DP_PRD: begin
				if (cmd.step != '0) begin
					vp_q[cap_idx][0] <= pos_rd_q[15:0];
					vp_q[cap_idx][1] <= pos_rd_q[31:16];
					vp_q[cap_idx][2] <= pos_rd_q[47:32];
				end
			end
			DP_XMUL: begin
				if (cmd.step == '0) begin
					for (int k = 0; k < 3; k++) begin
						e1_q[k] <= 17'(vp_q[1][k]) - 17'(vp_q[0][k]);
						e2_q[k] <= 17'(vp_q[2][k]) - 17'(vp_q[0][k]);
					end
				end
				prod_s1 <= mul_a * mul_b;
				case (cmd.step)
					STEP_W'(2): cross_q[0] <= 36'(prod_s1);
					STEP_W'(3): cross_q[0] <= cross_q[0] - 36'(prod_s1);
					STEP_W'(4): cross_q[1] <= 36'(prod_s1);
					STEP_W'(5): cross_q[1] <= cross_q[1] - 36'(prod_s1);
					STEP_W'(6): cross_q[2] <= 36'(prod_s1);
					STEP_W'(7): cross_q[2] <= cross_q[2] - 36'(prod_s1);
					default: ;
				endcase
			end
			DP_RLD: begin
				for (int k = 0; k < 3; k++) begin
					sgn_q[k] <= acc_rd_q[k*AB + AB - 1];
					mag_q[k] <= acc_rd_q[k*AB + AB - 1] ?
						(AB'(0) - acc_rd_q[k*AB +: AB]) : acc_rd_q[k*AB +: AB];
				end
				sum_q  <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end
			DP_SQ: begin
				sq_prod_s1 <= sq_a * sq_b;
				sq_sh_s1   <= 2'(cmd.step[1]) + 2'(cmd.step[0]);
				if (cmd.step != '0)
					sum_q <= sum_q + sq_ext[SUM_W-1:0];
			end
			DP_SQRT: begin
				sum_q <= sum_q << 2;
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[AB-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[AB-2:0], 1'b0};
				end
			end
			DP_DIV: begin
				if (cmd.step == '0) begin
					if (m_ext >= len_ext) begin
						dr_q <= m_ext - len_ext;
						q_q  <= 15'd1;
					end else begin
						dr_q <= m_ext;
						q_q  <= '0;
					end
				end else if (cmd.step == STEP_W'(15)) begin
					if (root_q == '0)
						nrm_q[dsel] <= '0;
					else
						nrm_q[dsel] <= sgn_q[dsel] ? (16'd0 - qext) : qext;
				end else if (dr_sh >= len_ext) begin
					dr_q <= dr_sh - len_ext;
					q_q  <= {q_q[13:0], 1'b1};
				end else begin
					dr_q <= dr_sh;
					q_q  <= {q_q[13:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.op == DP_FIN) begin
			status       <= res_status_q;
			vertex_index <= res_vidx_q;
			normal_x     <= nrm_q[0];
			normal_y     <= nrm_q[1];
			normal_z     <= nrm_q[2];
		end
	end

	`VNA_ASSERT(a_cnt_max, count_q <= CNT_W'(MAX_VERTICES))
	`VNA_ASSERT_NEXT(a_cnt_inc, cmd.op == DP_VADD, count_q == CNT_W'($past(count_q) + 1'b1))

endmodule

[tb/vertex_normal_accumulator_test.sv]
// Self-checking testbench for vertex_normal_accumulator: directed and random beats,
// a scoreboard class that predicts each result and random idling on both channels.
// Depends on vna_pkg and the vertex_normal_accumulator RTL.
`timescale 1ns / 1ps

module vertex_normal_accumulator_test;
	import vna_pkg::*;

	localparam int NVERT = VNA_MAX_VERTICES;
	localparam longint ACC_HI = (64'sd1 <<< (VNA_ACCUM_BITS - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  vidx;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
	} normal_result_t;

	// Mesh model: vertex positions, saturating normal sums, expected result beats
	class normal_scoreboard;
		longint pos[NVERT][3];
		longint acc[NVERT][3];
		int count;
		int errors;
		normal_result_t pending_q[$];

		function new();
			count = 0;
			errors = 0;
		endfunction

		function longint sat_sum(longint a, longint d);
			longint t;
			t = a + d;
			if (t > ACC_HI) return ACC_HI;
			if (t < ACC_LO) return ACC_LO;
			return t;
		endfunction

		function logic [15:0] unit_comp(longint c, longint unsigned len);
			longint unsigned m;
			longint unsigned q;
			m = (c < 0) ? -c : c;
			q = (m * 64'd16384) / len;
			return (c < 0) ? -q[15:0] : q[15:0];
		endfunction

		function normal_result_t vertex_normal(int v);
			normal_result_t r;
			bit [127:0] sumsq;
			bit [127:0] m;
			bit [127:0] cand;
			longint unsigned len;
			r = '0;
			sumsq = '0;
			for (int k = 0; k < 3; k++) begin
				m = (acc[v][k] < 0) ? -acc[v][k] : acc[v][k];
				sumsq += m * m;
			end
			// floor square root, one digit per pass
			len = 0;
			for (int b = 63; b >= 0; b--) begin
				cand = len | (64'd1 << b);
				if (cand * cand <= sumsq) len = cand[63:0];
			end
			if (len != 0) begin
				r.nx = unit_comp(acc[v][0], len);
				r.ny = unit_comp(acc[v][1], len);
				r.nz = unit_comp(acc[v][2], len);
			end
			return r;
		endfunction

		// accepted input beat: update the mesh and queue the result it causes
		function void note_beat(logic [1:0] act, logic [15:0] px, logic [15:0] py,
			logic [15:0] pz, logic [9:0] a, logic [9:0] b, logic [9:0] c);
			normal_result_t r;
			longint e1[3];
			longint e2[3];
			longint n[3];
			int idx[3];
			r = '0;
			case (act)
				ACT_VADD: begin
					if (count >= NVERT) r.status = STAT_FULL;
					else begin
						pos[count][0] = longint'($signed(px));
						pos[count][1] = longint'($signed(py));
						pos[count][2] = longint'($signed(pz));
						for (int k = 0; k < 3; k++) acc[count][k] = 0;
						r.vidx = count[9:0];
						count++;
					end
				end
				ACT_TRI: begin
					if (a >= count || b >= count || c >= count) r.status = STAT_IDX;
					else begin
						for (int k = 0; k < 3; k++) begin
							e1[k] = pos[b][k] - pos[a][k];
							e2[k] = pos[c][k] - pos[a][k];
						end
						n[0] = e1[1] * e2[2] - e1[2] * e2[1];
						n[1] = e1[2] * e2[0] - e1[0] * e2[2];
						n[2] = e1[0] * e2[1] - e1[1] * e2[0];
						idx[0] = a;
						idx[1] = b;
						idx[2] = c;
						// a corner listed twice is bumped twice
						foreach (idx[j])
							for (int k = 0; k < 3; k++)
								acc[idx[j]][k] = sat_sum(acc[idx[j]][k], n[k]);
					end
				end
				ACT_READ: begin
					if (a >= count) r.status = STAT_IDX;
					else r = vertex_normal(a);
				end
				default: ;
			endcase
			pending_q.push_back(r);
		endfunction

		function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
				errors++;
			end
		endfunction

		// accepted result beat: compare against the oldest expectation
		function void check_result(normal_result_t got);
			normal_result_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result beat, actual %0h", $time, got);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("vertex_index", want.vidx, got.vidx);
			compare_field("normal_x", want.nx, got.nx);
			compare_field("normal_y", want.ny, got.ny);
			compare_field("normal_z", want.nz, got.nz);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = ACT_NONE;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic signed [15:0] pos_z = '0;
	logic [9:0] corner_a = '0;
	logic [9:0] corner_b = '0;
	logic [9:0] corner_c = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [9:0] vertex_index;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;

	normal_scoreboard sb = new();
	bit quiet = 1'b0;
	int stall_cycles = 0;

	vertex_normal_accumulator dut (.*);

	always #2 clk = ~clk;

	// result side: check, then pick next ready at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({status, vertex_index, normal_x, normal_y, normal_z});
		out_ready <= quiet || ($urandom_range(99) >= 34);
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 5000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one input beat, with an optional random gap in front
	task automatic send_beat(logic [1:0] act, logic [15:0] px, logic [15:0] py,
		logic [15:0] pz, logic [9:0] a, logic [9:0] b, logic [9:0] c);
		while (!quiet && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		corner_a <= a;
		corner_b <= b;
		corner_c <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_beat(act, px, py, pz, a, b, c);
	endtask

	task automatic send_vertex();
		send_beat(ACT_VADD, 16'($urandom), 16'($urandom), 16'($urandom),
			10'($urandom), 10'($urandom), 10'($urandom));
	endtask

	function automatic logic [9:0] some_corner(bit broken);
		if (broken || sb.count == 0) return 10'($urandom);
		return 10'($urandom_range(sb.count - 1));
	endfunction

	initial begin
		int r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty mesh, unused code, extreme positions, degenerate cases
		send_beat(ACT_READ, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_TRI, 0, 0, 0, 0, 0, 0);
		send_beat(ACT_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF);
		send_beat(ACT_VADD, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
		send_beat(ACT_VADD, 16'h7FFF, 16'h8000, 16'h8000, 0, 0, 0);
		send_beat(ACT_VADD, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0);
		send_beat(ACT_VADD, 16'h8000, 16'h8000, 16'h7FFF, 0, 0, 0);
		send_beat(ACT_VADD, 16'h0000, 16'h0000, 16'h0000, 10'h3FF, 10'h3FF, 10'h3FF);
		send_beat(ACT_READ, 0, 0, 0, 4, 0, 0);
		send_beat(ACT_TRI, 0, 0, 0, 0, 1, 2);
		send_beat(ACT_TRI, 0, 0, 0, 3, 1, 3);
		send_beat(ACT_TRI, 0, 0, 0, 0, 1, 5);
		send_beat(ACT_TRI, 0, 0, 0, 2, 3, 1);
		send_beat(ACT_TRI, 0, 0, 0, 1, 1, 1);
		for (int v = 0; v < 4; v++) send_beat(ACT_READ, 0, 0, 0, 10'(v), 0, 0);
		send_beat(ACT_READ, 0, 0, 0, 5, 0, 0);
		send_beat(ACT_READ, 0, 0, 0, 10'h3FF, 0, 0);

		// random: mostly valid mesh traffic, some broken corners and unused codes
		for (int i = 0; i < 800; i++) begin
			quiet = (i >= 250 && i < 400);
			if (i == 500) begin
				in_valid <= 1'b0;
				while (sb.pending_q.size() != 0) @(posedge clk);
			end
			r = $urandom_range(99);
			if (r < 50) send_vertex();
			else if (r < 80) begin
				bit bad;
				bad = ($urandom_range(9) == 0);
				send_beat(ACT_TRI, 16'($urandom), 16'($urandom), 16'($urandom),
					some_corner(bad), some_corner(1'b0), some_corner(1'b0));
			end else if (r < 95)
				send_beat(ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom),
					some_corner($urandom_range(9) == 0), 10'($urandom), 10'($urandom));
			else
				send_beat(ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
					10'($urandom), 10'($urandom), 10'($urandom));
		end
		quiet = 1'b0;

		// fill the store, then hit the full case and the top slot
		while (sb.count < NVERT) send_vertex();
		repeat (3) send_vertex();
		send_beat(ACT_TRI, 0, 0, 0, 10'h3FF, 10'h3FE, 10'h3FD);
		send_beat(ACT_TRI, 0, 0, 0, 10'h3FD, 10'h3FF, 10'h000);
		send_beat(ACT_READ, 0, 0, 0, 10'h3FF, 0, 0);
		send_beat(ACT_READ, 0, 0, 0, 10'h3FD, 0, 0);
		send_beat(ACT_READ, 0, 0, 0, 10'h000, 0, 0);
		in_valid <= 1'b0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
